FILE: rtl/frm_pkg.sv
package frm_pkg;

  // record state between input transactions
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NAME,
    PH_CONTENT
  } phase_t;

  // output burst segments
  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_HEAD,   // AE 01 AA 04 "File" AE 02 AA 04 "name"
    SEG_NTAG,   // AA n | AB hi lo
    SEG_NAME,   // one name byte
    SEG_KEY,    // AA 05 "bytes"
    SEG_ATAG,   // AC n | AD hi lo
    SEG_UTAG,   // A2
    SEG_CBYTE   // one content byte
  } seg_t;

  localparam logic [7:0] TAG_U8  = 8'hA2;
  localparam logic [7:0] TAG_S8  = 8'hAA;
  localparam logic [7:0] TAG_S16 = 8'hAB;
  localparam logic [7:0] TAG_A8  = 8'hAC;
  localparam logic [7:0] TAG_A16 = 8'hAD;
  localparam logic [7:0] TAG_M8  = 8'hAE;

  localparam logic [7:0] KEY_RESET = 8'd42;

  localparam logic [4:0] HEAD_LAST = 5'd15;
  localparam logic [4:0] KEY_LAST  = 5'd6;

  // per-transaction burst description
  typedef struct packed {
    logic        nlong;    // 16-bit name length tag
    logic [15:0] nlen;
    logic        bytes_en; // "bytes" key and array header follow
    logic        along;    // 16-bit array header
    logic [15:0] alen;
    logic [7:0]  db;
    logic        clast;    // final content byte
  } item_t;

  function automatic logic [7:0] head_byte(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = TAG_M8;
      5'd1:    b = 8'h01;
      5'd2:    b = TAG_S8;
      5'd3:    b = 8'h04;
      5'd4:    b = 8'h46; // F
      5'd5:    b = 8'h69; // i
      5'd6:    b = 8'h6C; // l
      5'd7:    b = 8'h65; // e
      5'd8:    b = TAG_M8;
      5'd9:    b = 8'h02;
      5'd10:   b = TAG_S8;
      5'd11:   b = 8'h04;
      5'd12:   b = 8'h6E; // n
      5'd13:   b = 8'h61; // a
      5'd14:   b = 8'h6D; // m
      5'd15:   b = 8'h65; // e
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] key_byte(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = TAG_S8;
      5'd1:    b = 8'h05;
      5'd2:    b = 8'h62; // b
      5'd3:    b = 8'h79; // y
      5'd4:    b = 8'h74; // t
      5'd5:    b = 8'h65; // e
      5'd6:    b = 8'h73; // s
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/frm_in_if.sv
interface frm_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [15:0] name_length;
  logic [15:0] content_length;
  logic [7:0]  data_byte;

  modport source (output valid, start_req, name_length, content_length, data_byte,
                  input ready);
  modport sink   (input valid, start_req, name_length, content_length, data_byte,
                  output ready);
endinterface

FILE: rtl/frm_out_if.sv
interface frm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       record_end;

  modport source (output valid, out_byte, record_end, input ready);
  modport sink   (input valid, out_byte, record_end, output ready);
endinterface

FILE: rtl/frm_cfg_if.sv
interface frm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] xor_key;

  modport source (output valid, xor_key, input ready);
  modport sink   (input valid, xor_key, output ready);
endinterface

FILE: rtl/file_record_framer_top.sv
// A taken input transaction is registered as a burst; each burst byte then passes
// through the output register. One output byte per cycle unless the output stalls;
// bursts are 2 bytes for content, 1 for a name byte (the last one 10 or 11 with the
// "bytes" key and array header), 18 to 28 for a start, none for data outside a
// record. The byte sequencer's burst length sets the rate.
// Reset (rst, synchronous, active high): no record open, output empty,
// xor_key back to 42.
module file_record_framer_top (
  input  logic        clk,
  input  logic        rst,
  frm_in_if.sink      src,
  frm_out_if.source   snk,
  frm_cfg_if.sink     cfg
);

  // record state, updated when an input transaction is taken
  frm_pkg::phase_t phase, phase_next;
  logic [15:0] name_left, name_left_next;
  logic [15:0] content_left, content_left_next;
  logic [15:0] content_total, content_total_next;
  logic [7:0]  xor_key;

  // burst held for the sequencer
  frm_pkg::item_t item, item_next;
  frm_pkg::seg_t  seg, seg_next, seg_first, seg_adv;
  logic [4:0]     cnt, cnt_next, cnt_adv;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_end;

  logic       in_acc;
  logic       fire;
  logic       seg_done;   // current byte is the last of its segment
  logic       burst_done; // current byte is the last of the burst
  logic [7:0] byte_raw;
  logic       end_bit;
  logic [15:0] name_dec, content_dec;

  // sequencer advances whenever the output register is free or drains
  assign fire   = (seg != frm_pkg::SEG_NONE) && (!out_valid || snk.ready);
  // take a new transaction while the last byte of the current burst moves out
  assign src.ready = (seg == frm_pkg::SEG_NONE) || (fire && burst_done);
  assign in_acc = src.valid && src.ready;

  assign cfg.ready = 1'b1;

  assign name_dec    = name_left - 16'd1;
  assign content_dec = content_left - 16'd1;

  // record state update and burst selection for the incoming transaction
  always_comb begin
    phase_next         = phase;
    name_left_next     = name_left;
    content_left_next  = content_left;
    content_total_next = content_total;
    item_next          = item;
    seg_first          = frm_pkg::SEG_NONE;
    if (in_acc) begin
      item_next.db = src.data_byte;
      if (src.start_req) begin
        seg_first          = frm_pkg::SEG_HEAD;
        item_next.nlen     = src.name_length;
        item_next.nlong    = (src.name_length[15:8] != 8'd0);
        item_next.alen     = src.content_length;
        item_next.along    = (src.content_length[15:8] != 8'd0);
        item_next.bytes_en = (src.name_length == 16'd0);
        item_next.clast    = 1'b0;
        name_left_next     = src.name_length;
        content_total_next = src.content_length;
        content_left_next  = 16'd0;
        if (src.name_length == 16'd0) begin
          // empty name: jump straight to the content section
          content_left_next = src.content_length;
          phase_next = (src.content_length == 16'd0) ? frm_pkg::PH_IDLE
                                                     : frm_pkg::PH_CONTENT;
        end else begin
          phase_next = frm_pkg::PH_NAME;
        end
      end else begin
        unique case (phase)
          frm_pkg::PH_NAME: begin
            seg_first          = frm_pkg::SEG_NAME;
            name_left_next     = name_dec;
            item_next.bytes_en = (name_dec == 16'd0);
            item_next.alen     = content_total;
            item_next.along    = (content_total[15:8] != 8'd0);
            item_next.clast    = 1'b0;
            if (name_dec == 16'd0) begin
              content_left_next = content_total;
              phase_next = (content_total == 16'd0) ? frm_pkg::PH_IDLE
                                                    : frm_pkg::PH_CONTENT;
            end
          end
          frm_pkg::PH_CONTENT: begin
            seg_first         = frm_pkg::SEG_UTAG;
            content_left_next = content_dec;
            item_next.clast   = (content_dec == 16'd0);
            if (content_dec == 16'd0) begin
              phase_next = frm_pkg::PH_IDLE;
            end
          end
          default: begin
            // data outside a record is dropped
            seg_first = frm_pkg::SEG_NONE;
          end
        endcase
      end
    end
  end

  // sequencer next state
  always_comb begin
    seg_adv = seg;
    cnt_adv = cnt + 5'd1;
    if (seg_done) begin
      cnt_adv = 5'd0;
      unique case (seg)
        frm_pkg::SEG_HEAD:  seg_adv = frm_pkg::SEG_NTAG;
        frm_pkg::SEG_NTAG:  seg_adv = item.bytes_en ? frm_pkg::SEG_KEY : frm_pkg::SEG_NONE;
        frm_pkg::SEG_NAME:  seg_adv = item.bytes_en ? frm_pkg::SEG_KEY : frm_pkg::SEG_NONE;
        frm_pkg::SEG_KEY:   seg_adv = frm_pkg::SEG_ATAG;
        frm_pkg::SEG_UTAG:  seg_adv = frm_pkg::SEG_CBYTE;
        default:            seg_adv = frm_pkg::SEG_NONE;
      endcase
    end
  end

  always_comb begin
    if (in_acc) begin
      seg_next = seg_first;
      cnt_next = 5'd0;
    end else if (fire) begin
      seg_next = seg_adv;
      cnt_next = cnt_adv;
    end else begin
      seg_next = seg;
      cnt_next = cnt;
    end
  end

  // sequencer outputs: byte, end mark, segment and burst completion
  always_comb begin
    byte_raw = 8'h00;
    end_bit  = 1'b0;
    seg_done = 1'b1;
    unique case (seg)
      frm_pkg::SEG_HEAD: begin
        byte_raw = frm_pkg::head_byte(cnt);
        seg_done = (cnt == frm_pkg::HEAD_LAST);
      end
      frm_pkg::SEG_NTAG: begin
        if (item.nlong) begin
          byte_raw = (cnt == 5'd0) ? frm_pkg::TAG_S16 :
                     (cnt == 5'd1) ? item.nlen[15:8] : item.nlen[7:0];
          seg_done = (cnt == 5'd2);
        end else begin
          byte_raw = (cnt == 5'd0) ? frm_pkg::TAG_S8 : item.nlen[7:0];
          seg_done = (cnt == 5'd1);
        end
      end
      frm_pkg::SEG_NAME: begin
        byte_raw = item.db;
      end
      frm_pkg::SEG_KEY: begin
        byte_raw = frm_pkg::key_byte(cnt);
        seg_done = (cnt == frm_pkg::KEY_LAST);
      end
      frm_pkg::SEG_ATAG: begin
        if (item.along) begin
          byte_raw = (cnt == 5'd0) ? frm_pkg::TAG_A16 :
                     (cnt == 5'd1) ? item.alen[15:8] : item.alen[7:0];
          seg_done = (cnt == 5'd2);
        end else begin
          byte_raw = (cnt == 5'd0) ? frm_pkg::TAG_A8 : item.alen[7:0];
          seg_done = (cnt == 5'd1);
        end
        // empty content closes the record on the array header
        end_bit = seg_done && (item.alen == 16'd0);
      end
      frm_pkg::SEG_UTAG: begin
        byte_raw = frm_pkg::TAG_U8;
      end
      frm_pkg::SEG_CBYTE: begin
        byte_raw = item.db;
        end_bit  = item.clast;
      end
      default: begin
        byte_raw = 8'h00;
      end
    endcase
  end

  assign burst_done = seg_done && (seg_adv == frm_pkg::SEG_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= frm_pkg::PH_IDLE;
      name_left     <= 16'd0;
      content_left  <= 16'd0;
      content_total <= 16'd0;
      xor_key       <= frm_pkg::KEY_RESET;
      seg           <= frm_pkg::SEG_NONE;
      cnt           <= 5'd0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      name_left     <= name_left_next;
      content_left  <= content_left_next;
      content_total <= content_total_next;
      seg           <= seg_next;
      cnt           <= cnt_next;
      if (cfg.valid && cfg.ready) begin
        xor_key <= cfg.xor_key;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (snk.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item <= item_next;
    if (fire) begin
      out_byte <= byte_raw ^ xor_key;
      out_end  <= end_bit;
    end
  end

  assign snk.valid      = out_valid;
  assign snk.out_byte   = out_byte;
  assign snk.record_end = out_end;

endmodule

FILE: rtl/frm_checker.sv
module frm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_start,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_end
);

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_end))
    else $error("output changed under stall");

  // output empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a start transaction leaves the output valid once it has passed the burst and output registers
  a_start_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_start |=> ##1 out_valid)
    else $error("no header byte after start");

  // a stalled record end mark stays up until taken
  a_end_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end && !out_ready |=> out_valid && out_end)
    else $error("record end dropped under stall");

endmodule

bind file_record_framer_top frm_checker u_frm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (src.valid),
  .in_ready  (src.ready),
  .in_start  (src.start_req),
  .out_valid (snk.valid),
  .out_ready (snk.ready),
  .out_byte  (snk.out_byte),
  .out_end   (snk.record_end)
);

FILE: sim/tb_top.sv
module tb_top;

  // Map entry counts in the record header: outer map holds "File", inner map
  // holds "name" and "bytes".
  localparam logic [7:0] OUTER_ENTRIES = 8'h01;
  localparam logic [7:0] INNER_ENTRIES = 8'h02;

  // Cycles to let pass after the last expected byte before touching the key
  // register or ending the run; a start burst is at most 28 bytes.
  localparam int SETTLE_CYCLES = 32;

  // One encoded output byte as it should leave the block.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  logic clk = 1'b0;
  logic rst;

  frm_in_if  in_if ();
  frm_out_if out_if ();
  frm_cfg_if cfg_if ();

  file_record_framer_top dut (
    .clk (clk),
    .rst (rst),
    .src (in_if),
    .snk (out_if),
    .cfg (cfg_if)
  );

  // 10 time unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Encoder model: its own copy of the record state and the key register.
  // --------------------------------------------------------------------------
  frm_pkg::phase_t rec_phase;
  logic [15:0] name_due;
  logic [15:0] content_due;
  logic [15:0] content_len;
  logic [7:0]  scramble_key;

  enc_byte_t bytes_due[$];   // encoded bytes still owed by the block

  // pacing knobs shared between the test tasks and the channel processes
  bit src_gap_en;
  bit sink_stall_en;
  int sink_hold_cycles;

  int items_sent;
  int bytes_checked;
  int records_closed;
  int key_writes;
  int mismatches;

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    enc_byte_t e;
    e.value = b ^ scramble_key;
    e.last  = last;
    bytes_due = {bytes_due, e};
  endfunction

  // string key: S8 tag, length, characters
  function automatic void queue_key(input string s);
    queue_byte(frm_pkg::TAG_S8, 1'b0);
    queue_byte(8'(s.len()), 1'b0);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], 1'b0);
  endfunction

  // "bytes" key plus array header; an empty content list closes the record
  function automatic void queue_bytes_section();
    logic empty;
    empty = (content_len == 16'd0);
    queue_key("bytes");
    if (content_len < 16'd256) begin
      queue_byte(frm_pkg::TAG_A8, 1'b0);
      queue_byte(content_len[7:0], empty);
    end else begin
      queue_byte(frm_pkg::TAG_A16, 1'b0);
      queue_byte(content_len[15:8], 1'b0);
      queue_byte(content_len[7:0], empty);
    end
    content_due = content_len;
    rec_phase = empty ? frm_pkg::PH_IDLE : frm_pkg::PH_CONTENT;
  endfunction

  function automatic void encode_transaction(input logic start, input logic [15:0] nlen,
                                             input logic [15:0] clen, input logic [7:0] db);
    if (start) begin
      // a start always opens a fresh record, dropping any open one
      queue_byte(frm_pkg::TAG_M8, 1'b0);
      queue_byte(OUTER_ENTRIES, 1'b0);
      queue_key("File");
      queue_byte(frm_pkg::TAG_M8, 1'b0);
      queue_byte(INNER_ENTRIES, 1'b0);
      queue_key("name");
      if (nlen < 16'd256) begin
        queue_byte(frm_pkg::TAG_S8, 1'b0);
        queue_byte(nlen[7:0], 1'b0);
      end else begin
        queue_byte(frm_pkg::TAG_S16, 1'b0);
        queue_byte(nlen[15:8], 1'b0);
        queue_byte(nlen[7:0], 1'b0);
      end
      name_due    = nlen;
      content_len = clen;
      content_due = 16'd0;
      if (nlen == 16'd0)
        queue_bytes_section();
      else
        rec_phase = frm_pkg::PH_NAME;
    end else if (rec_phase == frm_pkg::PH_NAME) begin
      queue_byte(db, 1'b0);
      name_due = name_due - 16'd1;
      if (name_due == 16'd0)
        queue_bytes_section();
    end else if (rec_phase == frm_pkg::PH_CONTENT) begin
      content_due = content_due - 16'd1;
      queue_byte(frm_pkg::TAG_U8, 1'b0);
      queue_byte(db, content_due == 16'd0);
      if (content_due == 16'd0)
        rec_phase = frm_pkg::PH_IDLE;
    end
    // data while idle: dropped by the block, nothing owed
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and checker. Everything is sampled at the rising edge; output is
  // checked before the input transaction of the same edge is encoded, since
  // an output byte only leaves after its input transaction has been registered.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    enc_byte_t want;
    if (rst) begin
      rec_phase    = frm_pkg::PH_IDLE;
      name_due     = 16'd0;
      content_due  = 16'd0;
      content_len  = 16'd0;
      scramble_key = frm_pkg::KEY_RESET;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (out_if.record_end)
          records_closed++;
        if (bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output byte %h end %b", out_if.out_byte, out_if.record_end);
        end else begin
          want = bytes_due.pop_front();
          bytes_checked++;
          if (out_if.out_byte !== want.value || out_if.record_end !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output byte %0d: expected %h end %b, got %h end %b",
                       bytes_checked, want.value, want.last,
                       out_if.out_byte, out_if.record_end);
          end
        end
      end
      if (in_if.valid && in_if.ready)
        encode_transaction(in_if.start_req, in_if.name_length, in_if.content_length,
                           in_if.data_byte);
      if (cfg_if.valid && cfg_if.ready)
        scramble_key = cfg_if.xor_key;
    end
  end

  // --------------------------------------------------------------------------
  // Output side pacing: random stall bursts, or one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : sink_pacing
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        // long hold-off, counted down here so the sender keeps running
        out_if.ready = 1'b0;
        while (sink_hold_cycles > 0) begin
          @(negedge clk);
          sink_hold_cycles--;
        end
        out_if.ready = 1'b1;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Tasks are entered and left on a falling edge; valid stays up
  // after a transaction so back-to-back items need no drop in between. Any
  // task that waits without sending lowers it first.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic start, input logic [15:0] nlen,
                           input logic [15:0] clen, input logic [7:0] db);
    if (src_gap_en && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.start_req      = start;
    in_if.name_length    = nlen;
    in_if.content_length = clen;
    in_if.data_byte      = db;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // unused fields carry random noise on both kinds of transaction
  task automatic send_start(input logic [15:0] nlen, input logic [15:0] clen);
    send_item(1'b1, nlen, clen, 8'($urandom));
  endtask

  task automatic send_data(input logic [7:0] db);
    send_item(1'b0, 16'($urandom), 16'($urandom), db);
  endtask

  task automatic send_data_run(input int n);
    repeat (n) send_data(8'($urandom));
  endtask

  // sender pause: nothing offered until every owed byte is out
  task automatic wait_drain();
    in_if.valid = 1'b0;
    while (bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // key writes only once the block has gone quiet
  task automatic write_key(input logic [7:0] k);
    wait_drain();
    cfg_if.valid   = 1'b1;
    cfg_if.xor_key = k;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    key_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // smallest full record under the reset key
  task automatic test_basic_record();
    send_start(16'd1, 16'd1);
    send_data(8'h00);
    send_data(8'hFF);
  endtask

  // empty name, empty content, and both empty
  task automatic test_empty_sections();
    send_start(16'd0, 16'd0);
    send_start(16'd0, 16'd2);
    send_data(8'h80);
    send_data(8'h7F);
    send_start(16'd2, 16'd0);
    send_data(8'h55);
    send_data(8'hAA);
  endtask

  // data transactions with no record open are dropped
  task automatic test_stray_data();
    send_data(8'hFF);
    send_data(8'h00);
  endtask

  // 16-bit tags and length boundaries; records abandoned by a fresh start
  task automatic test_long_lengths();
    send_start(16'hFFFF, 16'hFFFF);
    send_data(8'($urandom));
    send_start(16'd2, 16'hFFFF);
    send_data_run(3);
    send_start(16'd0, 16'd256);
    send_data(8'($urandom));
    send_start(16'd255, 16'd255);
    send_start(16'd256, 16'd0);
    send_start(16'd0, 16'd0);
  endtask

  // output held off long enough that the block backs up into its input
  task automatic test_backpressure();
    sink_hold_cycles = 300;
    send_start(16'd3, 16'd10);
    send_data_run(13);
    wait_drain();
  endtask

  // sender goes quiet mid record, then finishes it
  task automatic test_mid_record_pause();
    send_start(16'd3, 16'd4);
    send_data_run(2);
    wait_drain();
    send_data_run(3);
    wait_drain();
    send_data_run(2);
  endtask

  // Mostly well-formed records with small sizes and random bytes; some
  // truncated records, some with full-range lengths, some stray data.
  // Ends with an empty record so the block is left idle.
  task automatic test_random_records(input int n_items);
    int sent;
    int kind;
    int cut;
    logic [15:0] nl;
    logic [15:0] cl;
    sent = 0;
    while (sent < n_items) begin
      kind = int'($urandom_range(0, 9));
      if (kind == 0) begin
        send_data(8'($urandom));
        sent += 1;
      end else if (kind == 1) begin
        nl  = 16'($urandom);
        cl  = 16'($urandom);
        cut = int'($urandom_range(0, 4));
        send_start(nl, cl);
        send_data_run(cut);
        sent += 1 + cut;
      end else if (kind == 2) begin
        nl  = 16'($urandom_range(0, 6));
        cl  = 16'($urandom_range(1, 6));
        cut = int'($urandom_range(0, int'(nl) + int'(cl) - 1));
        send_start(nl, cl);
        send_data_run(cut);
        sent += 1 + cut;
      end else begin
        nl = 16'($urandom_range(0, 6));
        cl = 16'($urandom_range(0, 6));
        send_start(nl, cl);
        send_data_run(int'(nl) + int'(cl));
        sent += 1 + int'(nl) + int'(cl);
      end
    end
    send_start(16'd0, 16'd0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    rst                  = 1'b1;
    in_if.valid          = 1'b0;
    in_if.start_req      = 1'b0;
    in_if.name_length    = 16'd0;
    in_if.content_length = 16'd0;
    in_if.data_byte      = 8'd0;
    cfg_if.valid         = 1'b0;
    cfg_if.xor_key       = 8'd0;
    src_gap_en           = 1'b0;
    sink_stall_en        = 1'b0;
    sink_hold_cycles     = 0;
    items_sent           = 0;
    bytes_checked        = 0;
    records_closed       = 0;
    key_writes           = 0;
    mismatches           = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset key first
    test_basic_record();
    src_gap_en    = 1'b1;
    sink_stall_en = 1'b1;
    write_key(8'h00);
    test_empty_sections();
    write_key(8'hFF);
    test_stray_data();
    test_long_lengths();

    // pressure, with the sender offering back to back
    write_key(8'($urandom));
    src_gap_en    = 1'b0;
    sink_stall_en = 1'b0;
    test_backpressure();
    src_gap_en    = 1'b1;
    sink_stall_en = 1'b1;
    test_mid_record_pause();

    // random traffic, idling on both sides
    test_random_records(25);
    write_key(8'($urandom));
    test_random_records(8);

    // closing stretch at full rate
    write_key(8'hFF);
    src_gap_en    = 1'b0;
    sink_stall_en = 1'b0;
    test_random_records(15);

    wait_drain();
    $display("covered %0d input transactions and %0d output bytes in %0d closed records,",
             items_sent, bytes_checked, records_closed);
    $display("across %0d key writes plus the reset key; %0d mismatches", key_writes, mismatches);
    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #10000000;
    $display("tb: failure");
    $finish;
  end

endmodule
